// File: design/assert_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

	localparam int WORD_W    = 32;
	localparam int WORD_SH   = 5;
	localparam int REQ_W     = 3;
	localparam int POS_W     = 11;
	localparam int LEN_W     = 12;
	localparam int IDX_W     = 11;
	localparam int CNT_W     = 12;
	localparam int CNT_LIMIT = (1 << CNT_W) - 1;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC_BLK = 3'd0,
		REQ_FREE_BLK  = 3'd1,
		REQ_ALLOC_INO = 3'd2,
		REQ_FREE_INO  = 3'd3,
		REQ_QUERY_BLK = 3'd4,
		REQ_QUERY_INO = 3'd5
	} req_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic init_wr;
		logic fail;
		logic scan_start;
		logic rd;
		logic bscan;
		logic bsetup;
		logic free_setup;
		logic mark;
		logic iscan;
		logic query_setup;
		logic q_take;
		logic count_upd;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		req_t req;
		logic init_last;
		logic blk_early_fail;
		logic range_empty;
		logic bhit;
		logic bend;
		logic ihit;
		logic iend;
		logic mark_last;
		logic out_ready;
	} dp_stat_t;

endpackage

// File: design/bba_ctrl.sv
// Sequencing state machine of the bitmap block allocator.
`include "assert_macros.svh"

module bba_ctrl
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_BSCAN,
		S_BSETUP,
		S_MARK,
		S_ISCAN,
		S_QREAD,
		S_QTAKE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	// Take a request only when idle
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Decode commands from the current state and datapath status
	always_comb begin
		cmd = '0;
		case (state_q)
			S_INIT: cmd.init_wr = 1'b1;
			S_IDLE: cmd.capture = accept;
			S_DECODE: begin
				case (stat.req)
					REQ_ALLOC_BLK: begin
						cmd.fail       = stat.blk_early_fail;
						cmd.scan_start = !stat.blk_early_fail;
					end
					REQ_FREE_BLK, REQ_FREE_INO: cmd.free_setup = !stat.range_empty;
					REQ_ALLOC_INO: cmd.scan_start = 1'b1;
					REQ_QUERY_BLK, REQ_QUERY_INO: cmd.query_setup = 1'b1;
					default: cmd.fail = 1'b1;
				endcase
			end
			S_BSCAN: begin
				cmd.bscan = 1'b1;
				cmd.rd    = !(stat.bhit || stat.bend);
				cmd.fail  = stat.bend;
			end
			S_BSETUP: cmd.bsetup = 1'b1;
			S_MARK: begin
				cmd.mark      = 1'b1;
				cmd.rd        = 1'b1;
				cmd.count_upd = stat.mark_last && (stat.req == REQ_ALLOC_BLK);
			end
			S_ISCAN: begin
				cmd.iscan = 1'b1;
				cmd.rd    = !(stat.ihit || stat.iend);
				cmd.fail  = stat.iend;
			end
			S_QREAD: cmd.rd = 1'b1;
			S_QTAKE: cmd.q_take = 1'b1;
			S_DONE: cmd.out_load = stat.out_ready;
			default: cmd = '0;
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					if (stat.init_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (stat.req)
						REQ_ALLOC_BLK: state_q <= stat.blk_early_fail ? S_DONE : S_BSCAN;
						REQ_FREE_BLK, REQ_FREE_INO: begin
							state_q <= stat.range_empty ? S_DONE : S_MARK;
						end
						REQ_ALLOC_INO: state_q <= S_ISCAN;
						REQ_QUERY_BLK, REQ_QUERY_INO: state_q <= S_QREAD;
						default: state_q <= S_DONE;
					endcase
				end
				S_BSCAN: begin
					if (stat.bhit) state_q <= S_BSETUP;
					else if (stat.bend) state_q <= S_DONE;
				end
				S_BSETUP: state_q <= S_MARK;
				S_MARK: begin
					if (stat.mark_last) state_q <= S_DONE;
				end
				S_ISCAN: begin
					if (stat.ihit || stat.iend) state_q <= S_DONE;
				end
				S_QREAD: state_q <= S_QTAKE;
				S_QTAKE: state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_decode, clk, arst_n, in_valid && !in_stall, state_q == S_DECODE, "accepted request not decoded")

endmodule

// File: design/bba_dpath.sv
// Bitmap memories, word search logic, counters and result register.
`include "assert_macros.svh"

module bba_dpath
	import bba_pkg::*;
#(
	parameter int BLOCK_MAP_BITS,
	parameter int INODE_MAP_BITS,
	parameter int RESERVED_BLOCKS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [REQ_W-1:0] req_type,
	input  logic [POS_W-1:0] position,
	input  logic [LEN_W-1:0] run_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             status,
	output logic [IDX_W-1:0] index,
	output logic             bit_set,
	output logic [CNT_W-1:0] free_blocks,
	output logic [CNT_W-1:0] used_blocks
);

	localparam int BWORDS = (BLOCK_MAP_BITS + WORD_W - 1) / WORD_W;
	localparam int IWORDS = (INODE_MAP_BITS + WORD_W - 1) / WORD_W;
	localparam int MAXW   = (BWORDS > IWORDS) ? BWORDS : IWORDS;
	localparam int PTRW   = $clog2(MAXW + 1);
	localparam int BWA    = (BWORDS > 1) ? $clog2(BWORDS) : 1;
	localparam int IWA    = (IWORDS > 1) ? $clog2(IWORDS) : 1;
	localparam int PW     = $clog2(MAXW * WORD_W + (1 << LEN_W));
	localparam int JW     = WORD_SH + 1;
	localparam int FREE_RST = (BLOCK_MAP_BITS > RESERVED_BLOCKS) ?
		((BLOCK_MAP_BITS - RESERVED_BLOCKS > CNT_LIMIT) ?
			CNT_LIMIT : BLOCK_MAP_BITS - RESERVED_BLOCKS) : 0;

	localparam logic [PW-1:0]   BMAP_P = PW'(BLOCK_MAP_BITS);
	localparam logic [PW-1:0]   IMAP_P = PW'(INODE_MAP_BITS);
	localparam logic [PW-1:0]   RES_P  = PW'(RESERVED_BLOCKS);
	localparam logic [PTRW-1:0] BLAST  = PTRW'(BWORDS - 1);
	localparam logic [PTRW-1:0] ILAST  = PTRW'(IWORDS - 1);
	localparam logic [PTRW-1:0] MLAST  = PTRW'(MAXW - 1);

	// Left shift that fills the vacated low bits with ones
	function automatic logic [WORD_W-1:0] shl_ones(input logic [WORD_W-1:0] x, input int s);
		shl_ones = (x << s) | ~({WORD_W{1'b1}} << s);
	endfunction

	// Request and walk registers
	logic [REQ_W-1:0]  req_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [PTRW-1:0]   ptr_q;
	logic [PTRW-1:0]   ptr_s1;
	logic              rvalid_s1;
	logic [LEN_W-1:0]  carry_q;
	logic [PW-1:0]     start_q;
	logic [PW-1:0]     frst_q;
	logic [PW-1:0]     last_q;
	logic              res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              res_bit_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  used_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [IDX_W-1:0]  out_index_q;
	logic              out_bit_q;
	logic [CNT_W-1:0]  out_free_q;
	logic [CNT_W-1:0]  out_used_q;

	// Bitmap storage
	logic [WORD_W-1:0] bmem [BWORDS];
	logic [WORD_W-1:0] imem [IWORDS];
	logic [WORD_W-1:0] brd_s1;
	logic [WORD_W-1:0] ird_s1;

	// Combinational signals
	logic              sel_blk;
	logic [PW-1:0]     map_bits;
	logic [PTRW-1:0]   words_last;
	logic [PW-1:0]     pos_w;
	logic [PW-1:0]     end_raw;
	logic [PW-1:0]     end_clamp;
	logic              pos_in_map;
	logic [WORD_W-1:0] rdata;
	logic [PTRW-1:0]   frst_word;
	logic [PTRW-1:0]   last_word;
	logic [PTRW-1:0]   lim;
	logic              rd_en;
	logic [JW-1:0]     lenc;
	logic [WORD_W-1:0] win;
	logic [WORD_W-1:0] acc;
	logic [LEN_W-1:0]  need;
	logic [WORD_W-1:0] hit_vec;
	logic [WORD_SH-1:0] j0;
	logic              found;
	logic [JW-1:0]     top_free;
	logic [LEN_W-1:0]  carry_next;
	logic [PW-1:0]     word_base;
	logic [PW-1:0]     bstart;
	logic [WORD_SH-1:0] ij0;
	logic              ifound;
	logic [PW-1:0]     ibase;
	logic [WORD_SH-1:0] lo;
	logic [WORD_SH-1:0] hi;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] mark_word;
	logic [WORD_W-1:0] ino_word;
	logic [WORD_W-1:0] binit;
	logic [WORD_W-1:0] iinit;
	logic [PW-1:0]     init_base;
	logic              bwr_en;
	logic              iwr_en;
	logic [PTRW-1:0]   wr_addr;
	logic [WORD_W-1:0] bwr_data;
	logic [WORD_W-1:0] iwr_data;
	logic              out_ready;
	logic [CNT_W:0]    used_sum;

	// Decode the map and range of the held request
	assign sel_blk    = (req_q == REQ_ALLOC_BLK) || (req_q == REQ_FREE_BLK) ||
		(req_q == REQ_QUERY_BLK);
	assign map_bits   = sel_blk ? BMAP_P : IMAP_P;
	assign words_last = sel_blk ? BLAST : ILAST;
	assign pos_w      = PW'(pos_q);
	assign end_raw    = pos_w + PW'(len_q) - PW'(1);
	assign end_clamp  = (end_raw >= map_bits) ? (map_bits - PW'(1)) : end_raw;
	assign pos_in_map = (pos_w < map_bits);
	assign rdata      = sel_blk ? brd_s1 : ird_s1;
	assign frst_word  = frst_q[WORD_SH+PTRW-1:WORD_SH];
	assign last_word  = last_q[WORD_SH+PTRW-1:WORD_SH];
	assign word_base  = PW'(ptr_s1) << WORD_SH;

	// Gate reads to the words of the current walk
	assign lim   = cmd.mark ? last_word : words_last;
	assign rd_en = cmd.rd && (ptr_q <= lim);

	// Find the first end of a free run of the requested length in this word
	assign lenc = (len_q >= LEN_W'(WORD_W)) ? JW'(WORD_W) : len_q[JW-1:0];
	assign need = len_q - carry_q;

	always_comb begin
		acc = ~rdata;
		win = '1;
		for (int k = 0; k < JW; k++) begin
			if (lenc[k]) win = acc & shl_ones(win, 1 << k);
			acc = acc & shl_ones(acc, 1 << k);
		end
		for (int j = 0; j < WORD_W; j++) begin
			hit_vec[j] = win[j] && (need <= LEN_W'(j + 1));
		end
	end

	always_comb begin
		j0 = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_vec[j]) j0 = WORD_SH'(j);
		end
	end
	assign found = |hit_vec;

	// Count free bits at the top of the word for the next word
	always_comb begin
		top_free = JW'(WORD_W);
		for (int j = 0; j < WORD_W; j++) begin
			if (rdata[j]) top_free = JW'(WORD_W - 1 - j);
		end
	end
	assign carry_next = (rdata == '0) ? (carry_q + LEN_W'(WORD_W)) : LEN_W'(top_free);
	assign bstart     = word_base + PW'(j0) + PW'(1) - PW'(len_q);

	// Lowest free inode in this word
	always_comb begin
		ij0 = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (!rdata[j]) ij0 = WORD_SH'(j);
		end
	end
	assign ifound   = (rdata != '1);
	assign ibase    = word_base + PW'(ij0);
	assign ino_word = rdata | (WORD_W'(1) << ij0);

	// Build the run mask for the word under modification
	assign lo        = (ptr_s1 == frst_word) ? frst_q[WORD_SH-1:0] : '0;
	assign hi        = (ptr_s1 == last_word) ? last_q[WORD_SH-1:0] : WORD_SH'(WORD_W - 1);
	assign mask      = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (WORD_SH'(WORD_W - 1) - hi));
	assign mark_word = (req_q == REQ_ALLOC_BLK) ? (rdata | mask) : (rdata & ~mask);

	// Reset contents: reserved blocks, inode zero and padding past the map end
	assign init_base = PW'(ptr_q) << WORD_SH;
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			binit[j] = ((init_base + PW'(j)) < RES_P) || ((init_base + PW'(j)) >= BMAP_P);
			iinit[j] = ((init_base + PW'(j)) == '0) || ((init_base + PW'(j)) >= IMAP_P);
		end
	end

	// Select the write port of each map
	assign bwr_en   = (cmd.init_wr && (ptr_q <= BLAST)) || (cmd.mark && rvalid_s1 && sel_blk);
	assign iwr_en   = (cmd.init_wr && (ptr_q <= ILAST)) ||
		(cmd.mark && rvalid_s1 && !sel_blk) || stat.ihit;
	assign wr_addr  = cmd.init_wr ? ptr_q : ptr_s1;
	assign bwr_data = cmd.init_wr ? binit : mark_word;
	assign iwr_data = cmd.init_wr ? iinit : (cmd.mark ? mark_word : ino_word);

	always_ff @(posedge clk) begin
		if (bwr_en) bmem[wr_addr[BWA-1:0]] <= bwr_data;
		if (rd_en && sel_blk) brd_s1 <= bmem[ptr_q[BWA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (iwr_en) imem[wr_addr[IWA-1:0]] <= iwr_data;
		if (rd_en && !sel_blk) ird_s1 <= imem[ptr_q[IWA-1:0]];
	end

	// Report status to the controller
	assign out_ready = !out_valid_q || !out_stall;
	assign used_sum  = {1'b0, used_q} + {1'b0, len_q};

	always_comb begin
		stat.req            = req_t'(req_q);
		stat.init_last      = (ptr_q == MLAST);
		stat.blk_early_fail = (free_q == '0) || (len_q == '0);
		stat.range_empty    = (len_q == '0) || !pos_in_map;
		stat.bhit           = cmd.bscan && rvalid_s1 && found;
		stat.bend           = cmd.bscan && rvalid_s1 && !found && (ptr_s1 == words_last);
		stat.ihit           = cmd.iscan && rvalid_s1 && ifound;
		stat.iend           = cmd.iscan && rvalid_s1 && !ifound && (ptr_s1 == words_last);
		stat.mark_last      = cmd.mark && rvalid_s1 && (ptr_s1 == last_word);
		stat.out_ready      = out_ready;
	end

	// Hold walk pointer, read pipeline flag, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			rvalid_s1   <= 1'b0;
			free_q      <= CNT_W'(FREE_RST);
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			if (cmd.scan_start) begin
				ptr_q <= '0;
			end else if (cmd.free_setup) begin
				ptr_q <= pos_w[WORD_SH+PTRW-1:WORD_SH];
			end else if (cmd.bsetup) begin
				ptr_q <= start_q[WORD_SH+PTRW-1:WORD_SH];
			end else if (cmd.query_setup) begin
				ptr_q <= pos_in_map ? pos_w[WORD_SH+PTRW-1:WORD_SH] : '0;
			end else if (rd_en || cmd.init_wr) begin
				ptr_q <= ptr_q + PTRW'(1);
			end
			if (cmd.count_upd) begin
				free_q <= (free_q > len_q) ? (free_q - len_q) : '0;
				used_q <= used_sum[CNT_W] ? CNT_W'(CNT_LIMIT) : used_sum[CNT_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold request fields, search state and results
	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
		if (cmd.capture) begin
			req_q        <= req_type;
			pos_q        <= position;
			len_q        <= run_length;
			res_status_q <= 1'b0;
			res_index_q  <= '0;
			res_bit_q    <= 1'b0;
		end
		if (cmd.fail) res_status_q <= 1'b1;
		if (cmd.scan_start) carry_q <= '0;
		if (cmd.bscan && rvalid_s1 && !found) carry_q <= carry_next;
		if (stat.bhit) start_q <= bstart;
		if (cmd.free_setup) begin
			frst_q <= pos_w;
			last_q <= end_clamp;
		end
		if (cmd.bsetup) begin
			frst_q      <= start_q;
			last_q      <= start_q + PW'(len_q) - PW'(1);
			res_index_q <= start_q[IDX_W-1:0];
		end
		if (stat.ihit) res_index_q <= ibase[IDX_W-1:0];
		if (cmd.q_take) res_bit_q <= pos_in_map && rdata[pos_q[WORD_SH-1:0]];
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_bit_q    <= res_bit_q;
			out_free_q   <= free_q;
			out_used_q   <= used_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign index       = out_index_q;
	assign bit_set     = out_bit_q;
	assign free_blocks = out_free_q;
	assign used_blocks = out_used_q;

	`ASSERT_IMPLIES(a_carry_below_len, clk, arst_n, cmd.bscan, carry_q < len_q, "free run carry reached request length")
	`ASSERT_IMPLIES(a_run_in_map, clk, arst_n, cmd.bsetup, (start_q + PW'(len_q)) <= BMAP_P, "allocated run passes map end")
	`ASSERT_IMPLIES(a_mark_in_range, clk, arst_n, cmd.mark && rvalid_s1, (ptr_s1 >= frst_word) && (ptr_s1 <= last_word), "run update outside its words")

endmodule

// File: design/bitmap_block_allocator.sv
// Bitmap block allocator: block and inode bitmaps with first-fit run allocation.
//
// Input channel (in_valid/in_stall) carries req_type, position and run_length;
// a transfer happens when in_valid is high and in_stall is low. Each request
// gives exactly one result on the output channel (out_valid/out_stall) with
// status, index, bit_set and the free and used block counters.
// One request is worked on at a time; the next may be taken while the last
// result still waits in the output register.
// Each bitmap memory has a single read port, which the search and the run
// update read one word of 32 bits a cycle; a block map of 2048 bits holds 64 words.
// After reset the maps are written with their start contents, one word a
// cycle over the larger map; in_stall stays high meanwhile. A stalled result
// holds; no further result is produced until it is taken.
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int BLOCK_MAP_BITS  = 2048,
	parameter int INODE_MAP_BITS  = 512,
	parameter int RESERVED_BLOCKS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [REQ_W-1:0] req_type,
	input  logic [POS_W-1:0] position,
	input  logic [LEN_W-1:0] run_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             status,
	output logic [IDX_W-1:0] index,
	output logic             bit_set,
	output logic [CNT_W-1:0] free_blocks,
	output logic [CNT_W-1:0] used_blocks
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each request
	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the maps and compute results
	bba_dpath #(
		.BLOCK_MAP_BITS  (BLOCK_MAP_BITS),
		.INODE_MAP_BITS  (INODE_MAP_BITS),
		.RESERVED_BLOCKS (RESERVED_BLOCKS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.position    (position),
		.run_length  (run_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.index       (index),
		.bit_set     (bit_set),
		.free_blocks (free_blocks),
		.used_blocks (used_blocks)
	);

endmodule
